@@ design/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Beat types, operation and status codes, and the saturation helpers shared
// by the top level and the divider pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

	// operation codes
	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_DIV  = 3'd3;
	localparam logic [2:0] CMD_CONJ = 3'd4;
	localparam logic [2:0] CMD_MOD  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// quotient bits resolved by the divider; anything larger saturates
	localparam int QB = 33;

	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic [1:0]         status;
	} rsp_beat_t;

	// control and finished results that ride along the divider
	typedef struct packed {
		logic        is_div;
		logic        dz;
		logic        neg_re;
		logic        neg_im;
		logic [31:0] nd_re;
		logic [31:0] nd_im;
		logic [1:0]  nd_st;
	} div_side_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} clamp_t;

	// clamp a sign and magnitude to 32-bit two's complement
	function automatic clamp_t clamp_sm(input logic neg, input logic [65:0] mag);
		clamp_t r;
		r.sat = 1'b0;
		r.val = 32'd0;
		if (neg) begin
			if (mag > 66'h0_8000_0000) begin
				r.sat = 1'b1;
				r.val = VAL_MIN;
			end else begin
				r.val = 32'd0 - mag[31:0];
			end
		end else if (mag > 66'h0_7FFF_FFFF) begin
			r.sat = 1'b1;
			r.val = VAL_MAX;
		end else begin
			r.val = mag[31:0];
		end
		return r;
	endfunction

	// clamp a signed value to 32-bit two's complement
	function automatic clamp_t clamp_s(input logic signed [65:0] v);
		logic [65:0] mag;
		mag = v[65] ? (66'd0 - $unsigned(v)) : $unsigned(v);
		return clamp_sm(v[65], mag);
	endfunction

endpackage

@@ design/cau_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider pipeline
// Restoring division of two magnitudes by a shared divisor, one quotient
// bit per stage, plus a leading stage that flags quotients beyond QB bits.
// ----------------------------------------------------------------------------
module cau_div
	import cau_pkg::*;
#(
	parameter int NW = 80
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [NW-1:0]   num_re,
	input  logic [NW-1:0]   num_im,
	input  logic [63:0]     den,
	input  div_side_t       side,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [QB:0]     quo_re,
	output logic [QB:0]     quo_im,
	output div_side_t       out_side
);

	localparam int CW = NW + QB;

	logic [QB:0]   v_s;
	logic [QB:0]   en;
	logic [NW-1:0] rre_s [QB+1];
	logic [NW-1:0] rim_s [QB+1];
	logic [QB-1:0] qre_s [QB+1];
	logic [QB-1:0] qim_s [QB+1];
	logic          ore_s [QB+1];
	logic          oim_s [QB+1];
	logic [63:0]   den_s [QB+1];
	div_side_t     side_s [QB+1];

	// advance a stage when it is empty or its successor advances
	assign en[QB] = !v_s[QB] || !out_stall;
	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_en
			assign en[k] = !v_s[k] || en[k+1];
		end
	endgenerate

	assign in_stall = !en[0];

	// flag quotients of more than QB bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rre_s[0]  <= num_re;
			rim_s[0]  <= num_im;
			qre_s[0]  <= '0;
			qim_s[0]  <= '0;
			ore_s[0]  <= (num_re >> QB) >= NW'(den);
			oim_s[0]  <= (num_im >> QB) >= NW'(den);
			den_s[0]  <= den;
			side_s[0] <= side;
		end
	end

	// resolve one quotient bit per stage, high bit first
	generate
		for (k = 1; k <= QB; k++) begin : g_bit
			localparam int B = QB - k;
			logic [CW-1:0] dsh;
			logic          take_re, take_im;

			assign dsh     = CW'(den_s[k-1]) << B;
			assign take_re = CW'(rre_s[k-1]) >= dsh;
			assign take_im = CW'(rim_s[k-1]) >= dsh;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					rre_s[k]  <= take_re ? NW'(CW'(rre_s[k-1]) - dsh) : rre_s[k-1];
					rim_s[k]  <= take_im ? NW'(CW'(rim_s[k-1]) - dsh) : rim_s[k-1];
					qre_s[k]  <= qre_s[k-1] | (QB'(take_re) << B);
					qim_s[k]  <= qim_s[k-1] | (QB'(take_im) << B);
					ore_s[k]  <= ore_s[k-1];
					oim_s[k]  <= oim_s[k-1];
					den_s[k]  <= den_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[QB];
	assign quo_re    = {ore_s[QB], qre_s[QB]};
	assign quo_im    = {oim_s[QB], qim_s[QB]};
	assign out_side  = side_s[QB];

	// a remainder never reaches the divisor once the last bit is taken
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QB] && side_s[QB].is_div && !side_s[QB].dz && !ore_s[QB]
		|-> (CW'(rre_s[QB]) < CW'(den_s[QB])))
		else $error("divider remainder not below divisor");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s[0])
		else $error("divider stalls with an empty entry stage");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QB] && out_stall |=> v_s[QB] && $stable(quo_re) && $stable(quo_im))
		else $error("divider output changed while stalled");

endmodule

@@ design/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate and squared modulus of signed
// fixed-point complex operands, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
// The unit takes one command beat per clock while cmd_stall is low and returns
// one response beat for each, in order. Each accepted command beat passes the
// input register, multiply, sum, prepare, 34 divider stages and the output
// register; every operation runs through the full pipeline, so the
// divider's one-bit-per-stage chain sets the latency while throughput stays
// one beat per cycle when nothing stalls. Stalls propagate back stage by stage,
// so empty stages fill up before cmd_stall rises.
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int NW = 64 + FRAC_BITS;

	logic v1_s, v2_s, v3_s, v4_s, v5_s;
	logic e1, e2, e3, e4, e5;
	logic div_in_stall, div_out_valid, div_out_stall;

	// stage 1: operands
	cmd_beat_t c_s1;

	// stage 2: products
	logic [2:0]         cmd_s2;
	logic signed [31:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [63:0] m0_s2, m1_s2, pri_s2, pir_s2, d0_s2, d1_s2;
	logic               dz_s2;

	// stage 3: sums
	logic [2:0]         cmd_s3;
	logic signed [65:0] re_s3, im_s3, sre_s3, sim_s3;
	logic [63:0]        den_s3;
	logic               dz_s3;

	// stage 4: divider operands and finished results
	logic [NW-1:0]      nre_s4, nim_s4;
	logic [63:0]        den_s4;
	div_side_t          side_s4;

	logic [QB:0]        quo_re, quo_im;
	div_side_t          dside;

	// advance chain, back from the output register
	assign e5 = !v5_s || !rsp_stall;
	assign div_out_stall = !e5;
	assign e4 = !v4_s || !div_in_stall;
	assign e3 = !v3_s || e4;
	assign e2 = !v2_s || e3;
	assign e1 = !v1_s || e2;
	assign cmd_stall = !e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
			v4_s <= 1'b0;
		end else begin
			if (e1) v1_s <= cmd_valid;
			if (e2) v2_s <= v1_s;
			if (e3) v3_s <= v2_s;
			if (e4) v4_s <= v3_s;
		end
	end

	// capture operands
	always_ff @(posedge clk) begin
		if (e1) begin
			c_s1 <= cmd;
		end
	end

	// multiply; squared modulus reuses the first two multipliers
	logic signed [31:0] opb0, opb1;
	assign opb0 = (c_s1.command == CMD_MOD) ? c_s1.a_re : c_s1.b_re;
	assign opb1 = (c_s1.command == CMD_MOD) ? c_s1.a_im : c_s1.b_im;

	always_ff @(posedge clk) begin
		if (e2) begin
			cmd_s2 <= c_s1.command;
			ar_s2  <= c_s1.a_re;
			ai_s2  <= c_s1.a_im;
			br_s2  <= c_s1.b_re;
			bi_s2  <= c_s1.b_im;
			m0_s2  <= c_s1.a_re * opb0;
			m1_s2  <= c_s1.a_im * opb1;
			pri_s2 <= c_s1.a_re * c_s1.b_im;
			pir_s2 <= c_s1.a_im * c_s1.b_re;
			d0_s2  <= c_s1.b_re * c_s1.b_re;
			d1_s2  <= c_s1.b_im * c_s1.b_im;
			dz_s2  <= (c_s1.b_re == 32'sd0) && (c_s1.b_im == 32'sd0);
		end
	end

	// form the exact sums of products and the plain results
	always_ff @(posedge clk) begin
		if (e3) begin
			cmd_s3 <= cmd_s2;
			dz_s3  <= dz_s2;
			re_s3  <= (cmd_s2 == CMD_MUL) ? 66'(m0_s2) - 66'(m1_s2)
			                              : 66'(m0_s2) + 66'(m1_s2);
			im_s3  <= (cmd_s2 == CMD_MUL) ? 66'(pri_s2) + 66'(pir_s2)
			                              : 66'(pir_s2) - 66'(pri_s2);
			den_s3 <= 64'($unsigned(d0_s2)) + 64'($unsigned(d1_s2));
			unique case (cmd_s2)
				CMD_ADD: begin
					sre_s3 <= 66'(ar_s2) + 66'(br_s2);
					sim_s3 <= 66'(ai_s2) + 66'(bi_s2);
				end
				CMD_SUB: begin
					sre_s3 <= 66'(ar_s2) - 66'(br_s2);
					sim_s3 <= 66'(ai_s2) - 66'(bi_s2);
				end
				default: begin
					sre_s3 <= 66'(ar_s2);
					sim_s3 <= 66'sd0 - 66'(ai_s2);
				end
			endcase
		end
	end

	// split sums into sign and magnitude, finish everything but divide
	logic        nre, nim;
	logic [63:0] mre, mim;
	clamp_t      cr, ci;
	div_side_t   side_d;

	always_comb begin
		nre = re_s3[65];
		nim = im_s3[65];
		mre = nre ? 64'(66'd0 - $unsigned(re_s3)) : 64'($unsigned(re_s3));
		mim = nim ? 64'(66'd0 - $unsigned(im_s3)) : 64'($unsigned(im_s3));
		cr  = '0;
		ci  = '0;
		unique case (cmd_s3)
			CMD_ADD, CMD_SUB, CMD_CONJ: begin
				cr = clamp_s(sre_s3);
				ci = clamp_s(sim_s3);
			end
			CMD_MUL: begin
				cr = clamp_sm(nre, 66'(mre) >> FRAC_BITS);
				ci = clamp_sm(nim, 66'(mim) >> FRAC_BITS);
			end
			CMD_MOD: begin
				cr = clamp_sm(1'b0, 66'(mre) >> FRAC_BITS);
			end
			default: begin
				cr = '0;
				ci = '0;
			end
		endcase
		side_d.is_div = (cmd_s3 == CMD_DIV);
		side_d.dz     = dz_s3;
		side_d.neg_re = nre;
		side_d.neg_im = nim;
		side_d.nd_re  = cr.val;
		side_d.nd_im  = ci.val;
		side_d.nd_st  = (cr.sat || ci.sat) ? ST_SAT : ST_OK;
	end

	always_ff @(posedge clk) begin
		if (e4) begin
			nre_s4  <= NW'(mre) << FRAC_BITS;
			nim_s4  <= NW'(mim) << FRAC_BITS;
			den_s4  <= den_s3;
			side_s4 <= side_d;
		end
	end

	cau_div #(
		.NW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v4_s),
		.in_stall (div_in_stall),
		.num_re   (nre_s4),
		.num_im   (nim_s4),
		.den      (den_s4),
		.side     (side_s4),
		.out_valid(div_out_valid),
		.out_stall(div_out_stall),
		.quo_re   (quo_re),
		.quo_im   (quo_im),
		.out_side (dside)
	);

	// finish divide and hold the response beat
	clamp_t    qr, qi;
	rsp_beat_t rsp_d;

	always_comb begin
		qr = clamp_sm(dside.neg_re, 66'(quo_re));
		qi = clamp_sm(dside.neg_im, 66'(quo_im));
		priority if (dside.is_div && dside.dz) begin
			rsp_d.res_re = '0;
			rsp_d.res_im = '0;
			rsp_d.status = ST_DZ;
		end else if (dside.is_div) begin
			rsp_d.res_re = qr.val;
			rsp_d.res_im = qi.val;
			rsp_d.status = (qr.sat || qi.sat) ? ST_SAT : ST_OK;
		end else begin
			rsp_d.res_re = dside.nd_re;
			rsp_d.res_im = dside.nd_im;
			rsp_d.status = dside.nd_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v5_s <= 1'b0;
		end else if (e5) begin
			v5_s <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (e5) begin
			rsp <= rsp_d;
		end
	end

	assign rsp_valid = v5_s;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_DZ |-> rsp.res_re == '0 && rsp.res_im == '0)
		else $error("divide by zero beat carries a nonzero result");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_SAT
		|-> (rsp.res_re == VAL_MAX || rsp.res_re == VAL_MIN
		     || rsp.res_im == VAL_MAX || rsp.res_im == VAL_MIN))
		else $error("saturated beat without a limit value");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> v1_s && v2_s && v3_s && v4_s)
		else $error("command stalled with an empty stage ahead");

endmodule

@@ test/cau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Watches both channels, predicts each response beat from its command beat
// and compares the two field by field in order.
// ----------------------------------------------------------------------------
module cau_checker
	import cau_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_stall,
	input  cmd_beat_t cmd,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_beat_t rsp,
	output int        errors,
	output int        pending
);

	rsp_beat_t result_q[$];

	// clamp a sign and magnitude to 32 bits, flag saturation
	function automatic logic [31:0] sat32(input logic neg, input logic [127:0] mag,
			inout logic sat);
		if (neg) begin
			if (mag > 128'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'd0 - mag[31:0];
		end
		if (mag > 128'h7FFF_FFFF) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return mag[31:0];
	endfunction

	function automatic logic [127:0] mag_of(input logic signed [127:0] v);
		return v[127] ? 128'(-v) : 128'(v);
	endfunction

	// compute the expected truncated and saturated result of one command beat
	function automatic rsp_beat_t complex_result(input cmd_beat_t c);
		logic signed [127:0] ar, ai, br, bi, s;
		logic [127:0] den;
		logic sat;
		rsp_beat_t r;
		ar = c.a_re;
		ai = c.a_im;
		br = c.b_re;
		bi = c.b_im;
		sat = 1'b0;
		r = '0;
		case (c.command)
			CMD_ADD: begin
				s = ar + br;
				r.res_re = sat32(s[127], mag_of(s), sat);
				s = ai + bi;
				r.res_im = sat32(s[127], mag_of(s), sat);
			end
			CMD_SUB: begin
				s = ar - br;
				r.res_re = sat32(s[127], mag_of(s), sat);
				s = ai - bi;
				r.res_im = sat32(s[127], mag_of(s), sat);
			end
			CMD_MUL: begin
				s = ar * br - ai * bi;
				r.res_re = sat32(s[127], mag_of(s) >> FRAC_BITS, sat);
				s = ar * bi + ai * br;
				r.res_im = sat32(s[127], mag_of(s) >> FRAC_BITS, sat);
			end
			CMD_DIV: begin
				if (c.b_re == 0 && c.b_im == 0) begin
					r.status = ST_DZ;
				end else begin
					den = 128'(br * br + bi * bi);
					s = ar * br + ai * bi;
					r.res_re = sat32(s[127], (mag_of(s) << FRAC_BITS) / den, sat);
					s = ai * br - ar * bi;
					r.res_im = sat32(s[127], (mag_of(s) << FRAC_BITS) / den, sat);
				end
			end
			CMD_CONJ: begin
				r.res_re = c.a_re;
				s = -ai;
				r.res_im = sat32(s[127], mag_of(s), sat);
			end
			CMD_MOD: begin
				s = ar * ar + ai * ai;
				r.res_re = sat32(1'b0, 128'(s) >> FRAC_BITS, sat);
			end
			default: ;
		endcase
		if (sat && r.status == ST_OK)
			r.status = ST_SAT;
		return r;
	endfunction

	// queue predictions on command beats, compare on response beats
	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				result_q.push_back(complex_result(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected response beat: %h", rsp);
					errors <= errors + 1;
				end else begin
					want = result_q.pop_front();
					if (want !== rsp) begin
						if (errors < 10)
							$display("mismatch: exp re %h im %h st %0d, got re %h im %h st %0d",
								want.res_re, want.res_im, want.status,
								rsp.res_re, rsp.res_im, rsp.status);
						errors <= errors + 1;
					end
				end
			end
			pending <= result_q.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed corner beats and random beats with random gaps and
// response stalls; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb
	import cau_pkg::*;
();

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int         CYCLE_LIMIT  = 400000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_beat_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp;
	int        errors;
	int        pending;
	int        cycles;
	logic      quiet = 1'b0;

	complex_arithmetic_unit dut (.*);

	cau_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mostly short gaps, a few long ones, none in quiet stretches
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 8)) - 4);
			3: return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			default: return $urandom;
		endcase
	endfunction

	// toggle quiet stretches now and then
	always @(negedge clk)
		if ($urandom_range(0, 199) == 0)
			quiet <= ~quiet;

	// hold off the response side in random runs
	initial begin
		int g;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				rsp_stall <= 1'b1;
				repeat (g) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one beat and hold it until accepted
	task automatic send_beat(input cmd_beat_t b);
		int g;
		g = gap_len();
		if (g > 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= b;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_ops(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		cmd_beat_t b;
		b.command = op;
		b.a_re = ar;
		b.a_im = ai;
		b.b_re = br;
		b.b_im = bi;
		send_beat(b);
	endtask

	initial begin
		cmd_beat_t b;
		cmd_valid = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners: extremes, zero divisor, conj of the minimum, spare codes
		send_ops(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_ops(CMD_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000);
		send_ops(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_ops(CMD_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
		send_ops(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_ops(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_ops(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
		send_ops(CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
		send_ops(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
		send_ops(CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
		send_ops(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_ops(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
		send_ops(CMD_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
		send_ops(CMD_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		send_ops(CMD_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_ops(CMD_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_ops(CMD_MOD, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_ops(CMD_MOD, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0, 32'h0);
		send_ops(CMD_MOD, 32'h0001_0000, 32'h0001_0000, 32'h1234_5678, 32'h9ABC_DEF0);
		send_ops(CMD_SPARE_LO, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1);
		send_ops(CMD_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// random beats, weighted toward the real operations
		repeat (450) begin
			b.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			b.a_re = pick_val();
			b.a_im = pick_val();
			b.b_re = pick_val();
			b.b_im = pick_val();
			if (b.command == CMD_DIV && $urandom_range(0, 9) == 0) begin
				b.b_re = '0;
				b.b_im = '0;
			end
			send_beat(b);
		end
		cmd_valid <= 1'b0;

		// drain the pipeline, then allow for its latency
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
